>>> rtl/core/fesg_pkg.sv
// fesg_pkg: shared types and constants for the filled ellipse span generator
// no dependencies; imported by filled_ellipse_span_generator and its bench
`timescale 1ns / 1ps

package fesg_pkg;

   // configuration port
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FILL_COLOR = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RASTER_OP  = 4'd1;

   // request mode codes
   localparam logic MODE_START = 1'b0;
   localparam logic MODE_STEP  = 1'b1;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,      // no ellipse loaded
      ST_WAIT,      // ellipse loaded, waiting for a step
      ST_MUL_XX,    // x radius squared, shift-add
      ST_MUL_YY,    // y radius squared, shift-add
      ST_MUL_P,     // y radius times x radius squared, shift-add
      ST_SET_E,     // initial error term
      ST_SET_DY,    // initial row decrement
      ST_GROW_E,    // widen while error is non-positive
      ST_GROW_D,    // advance the width increment
      ST_ROW_E,     // apply the row decrement to the error
      ST_ROW_D,     // advance the row decrement
      ST_EMIT,      // hand the span pair to the output register
      ST_EMIT_ERR   // hand the misaligned-axes result to the output register
   } state_type;

endpackage

>>> rtl/core/filled_ellipse_span_generator.sv
// filled_ellipse_span_generator: midpoint ellipse scan conversion into row spans
// depends on fesg_pkg; one shared wide adder/subtractor under a small sequencer
`timescale 1ns / 1ps

// A start request (mode 0) takes the center and two axis endpoints; the first endpoint
// sets the x radius and the second the y radius, each saturated to 2^(COORD_BITS-1)-1.
// A start gives no result unless both endpoints are off the vertical through the center,
// in which case one result with misaligned and last_row set comes out and nothing else.
// Each later step request (mode 1) gives one span pair, from the top row offset down to
// row 0, where last_row is set; steps with no ellipse loaded are taken and give nothing.
// Products, error terms and increments share one adder of 3*COORD_BITS+2 bits. A start
// runs three shift-add products and two setup steps. A step alternates ST_GROW_E and
// ST_GROW_D once per half-width increment on that row, then runs ST_ROW_E, ST_ROW_D and
// ST_EMIT, where it waits while the output register is full. A misaligned start waits
// only in ST_EMIT_ERR for that register. Configuration writes are always accepted.
module filled_ellipse_span_generator
   import fesg_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,

   // configuration write channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_data,

   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_mode,
   input  logic signed [COORD_BITS-1:0]  req_center_x,
   input  logic signed [COORD_BITS-1:0]  req_center_y,
   input  logic signed [COORD_BITS-1:0]  req_major_end_x,
   input  logic signed [COORD_BITS-1:0]  req_major_end_y,
   input  logic signed [COORD_BITS-1:0]  req_minor_end_x,
   input  logic signed [COORD_BITS-1:0]  req_minor_end_y,

   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [COORD_BITS-1:0]  rsp_left_x,
   output logic signed [COORD_BITS-1:0]  rsp_right_x,
   output logic signed [COORD_BITS-1:0]  rsp_upper_row,
   output logic signed [COORD_BITS-1:0]  rsp_lower_row,
   output logic [CSR_DATA_BITS-1:0]      rsp_span_color,
   output logic [CSR_DATA_BITS-1:0]      rsp_span_op,
   output logic                          rsp_last_row,
   output logic                          rsp_misaligned
);

   localparam int CW    = COORD_BITS;
   localparam int RW    = CW - 1;          // saturated radius
   localparam int SW    = 2 * RW;          // radius squared
   localparam int HW    = CW + 1;          // half-width
   localparam int EW    = 3 * CW + 2;      // error term and increments
   localparam int CNT_W = $clog2(CW);

   // magnitude of a wrapped difference, saturated to the radius range
   function automatic logic [RW-1:0] mag_diff(input logic [CW-1:0] e, input logic [CW-1:0] c);
      logic [CW-1:0] d;
      logic [CW-1:0] n;
      d = e - c;
      n = -d;
      if (!d[CW-1]) begin
         mag_diff = d[RW-1:0];
      end else if (n[CW-1]) begin
         mag_diff = {RW{1'b1}};
      end else begin
         mag_diff = n[RW-1:0];
      end
   endfunction

   // sequencer and datapath registers
   state_type       state_ff, state_in;
   logic [CW-1:0]   org_x_ff, org_x_in;
   logic [CW-1:0]   org_y_ff, org_y_in;
   logic [CW-1:0]   row_ff, row_in;
   logic [HW-1:0]   hw_ff, hw_in;
   logic [RW-1:0]   rx_ff, rx_in;
   logic            zero_x_ff, zero_x_in;
   logic [SW-1:0]   xsq_ff, xsq_in;
   logic [SW-1:0]   ysq_ff, ysq_in;
   logic [EW-1:0]   err_ff, err_in;
   logic [EW-1:0]   dx_ff, dx_in;
   logic [EW-1:0]   dy_ff, dy_in;
   logic [EW-1:0]   acc_ff, acc_in;
   logic [EW-1:0]   mcand_ff, mcand_in;
   logic [RW-1:0]   mplier_ff, mplier_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // configuration registers
   logic [CSR_DATA_BITS-1:0] color_ff, color_in;
   logic [CSR_DATA_BITS-1:0] rop_ff, rop_in;

   // output register
   logic                     out_valid_ff, out_valid_in;
   logic [CW-1:0]            out_left_ff, out_left_in;
   logic [CW-1:0]            out_right_ff, out_right_in;
   logic [CW-1:0]            out_upper_ff, out_upper_in;
   logic [CW-1:0]            out_lower_ff, out_lower_in;
   logic [CSR_DATA_BITS-1:0] out_color_ff, out_color_in;
   logic [CSR_DATA_BITS-1:0] out_op_ff, out_op_in;
   logic                     out_last_ff, out_last_in;
   logic                     out_mis_ff, out_mis_in;

   // shared adder/subtractor
   logic [EW-1:0] add_a;
   logic [EW-1:0] add_b;
   logic          add_sub;
   logic [EW-1:0] add_sum;

   // start decode
   logic [CW-1:0] dx1;
   logic [CW-1:0] dx2;
   logic [RW-1:0] rx_new;
   logic [RW-1:0] ry_new;
   logic          axes_bad;

   logic          req_xfer;
   logic          rsp_free;
   logic          err_le_zero;
   logic [EW-1:0] xsq_ext;
   logic [EW-1:0] ysq2_ext;
   logic [EW-1:0] xsq2_ext;
   logic [HW-1:0] org_x_ext;
   logic [HW-1:0] left_sum;
   logic [HW-1:0] right_sum;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE) || (state_ff == ST_WAIT);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_free  = !out_valid_ff || rsp_ready;

   // axis offsets and radii of a start request
   assign dx1      = CW'(req_major_end_x) - CW'(req_center_x);
   assign dx2      = CW'(req_minor_end_x) - CW'(req_center_x);
   assign axes_bad = (dx1 != '0) && (dx2 != '0);
   assign rx_new   = (dx1 == '0) ? mag_diff(req_major_end_y, req_center_y)
                                 : mag_diff(req_major_end_x, req_center_x);
   assign ry_new   = (dx2 == '0) ? mag_diff(req_minor_end_y, req_center_y)
                                 : mag_diff(req_minor_end_x, req_center_x);

   assign err_le_zero = err_ff[EW-1] || (err_ff == '0);
   assign xsq_ext     = {{(EW-SW){1'b0}}, xsq_ff};
   assign xsq2_ext    = {{(EW-SW-1){1'b0}}, xsq_ff, 1'b0};
   assign ysq2_ext    = {{(EW-SW-1){1'b0}}, ysq_ff, 1'b0};

   // span edges around the center
   assign org_x_ext = {1'b0, org_x_ff};
   assign left_sum  = org_x_ext - hw_ff;
   assign right_sum = org_x_ext + hw_ff;

   // operand selection for the shared adder
   always_comb begin
      add_a   = '0;
      add_b   = '0;
      add_sub = 1'b0;
      unique case (state_ff)
         ST_MUL_XX, ST_MUL_YY, ST_MUL_P: begin
            add_a = acc_ff;
            add_b = mplier_ff[0] ? mcand_ff : '0;
         end
         ST_SET_E: begin
            add_b   = acc_ff;
            add_sub = 1'b1;
         end
         ST_SET_DY: begin
            add_a   = {acc_ff[EW-2:0], 1'b0};
            add_b   = xsq_ext;
            add_sub = 1'b1;
         end
         ST_GROW_E: begin
            add_a = err_ff;
            add_b = dx_ff;
         end
         ST_GROW_D: begin
            add_a = dx_ff;
            add_b = ysq2_ext;
         end
         ST_ROW_E: begin
            add_a   = err_ff;
            add_b   = dy_ff;
            add_sub = 1'b1;
         end
         ST_ROW_D: begin
            add_a   = dy_ff;
            add_b   = xsq2_ext;
            add_sub = 1'b1;
         end
         default: begin
            add_a = '0;
         end
      endcase
   end

   assign add_sum = add_a + (add_sub ? ~add_b : add_b) + {{(EW-1){1'b0}}, add_sub};

   // next state and datapath updates
   always_comb begin
      state_in     = state_ff;
      org_x_in     = org_x_ff;
      org_y_in     = org_y_ff;
      row_in       = row_ff;
      hw_in        = hw_ff;
      rx_in        = rx_ff;
      zero_x_in    = zero_x_ff;
      xsq_in       = xsq_ff;
      ysq_in       = ysq_ff;
      err_in       = err_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      acc_in       = acc_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      cnt_in       = cnt_ff;
      color_in     = color_ff;
      rop_in       = rop_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_left_in  = out_left_ff;
      out_right_in = out_right_ff;
      out_upper_in = out_upper_ff;
      out_lower_in = out_lower_ff;
      out_color_in = out_color_ff;
      out_op_in    = out_op_ff;
      out_last_in  = out_last_ff;
      out_mis_in   = out_mis_ff;

      // configuration write
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FILL_COLOR: color_in = csr_data;
            CSR_RASTER_OP:  rop_in   = csr_data;
            default:        color_in = color_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE, ST_WAIT: begin
            if (req_xfer) begin
               if (req_mode == MODE_START) begin
                  if (axes_bad) begin
                     state_in = ST_EMIT_ERR;
                  end else begin
                     org_x_in  = CW'(req_center_x);
                     org_y_in  = CW'(req_center_y);
                     row_in    = {1'b0, ry_new};
                     rx_in     = rx_new;
                     zero_x_in = (rx_new == '0);
                     acc_in    = '0;
                     mcand_in  = {{(EW-RW){1'b0}}, rx_new};
                     mplier_in = rx_new;
                     cnt_in    = CNT_W'(CW - 2);
                     state_in  = ST_MUL_XX;
                  end
               end else if (state_ff == ST_WAIT) begin
                  state_in = ST_GROW_E;
               end
            end
         end

         ST_MUL_XX, ST_MUL_YY, ST_MUL_P: begin
            acc_in    = add_sum;
            mcand_in  = {mcand_ff[EW-2:0], 1'b0};
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               acc_in = '0;
               cnt_in = CNT_W'(CW - 2);
               if (state_ff == ST_MUL_XX) begin
                  xsq_in    = add_sum[SW-1:0];
                  mcand_in  = {{(EW-RW){1'b0}}, row_ff[RW-1:0]};
                  mplier_in = row_ff[RW-1:0];
                  state_in  = ST_MUL_YY;
               end else if (state_ff == ST_MUL_YY) begin
                  ysq_in    = add_sum[SW-1:0];
                  dx_in     = add_sum;
                  mcand_in  = xsq_ext;
                  mplier_in = row_ff[RW-1:0];
                  state_in  = ST_MUL_P;
               end else begin
                  acc_in   = add_sum;
                  state_in = ST_SET_E;
               end
            end
         end

         ST_SET_E: begin
            // error term scaled by the x radius squared
            if (zero_x_ff) begin
               hw_in  = HW'(1);
               err_in = '0;
            end else if (row_ff == '0) begin
               hw_in  = {2'b00, rx_ff};
               err_in = EW'(1);
            end else begin
               hw_in  = '0;
               err_in = add_sum;
            end
            state_in = ST_SET_DY;
         end

         ST_SET_DY: begin
            dy_in    = add_sum;
            state_in = ST_WAIT;
         end

         ST_GROW_E: begin
            if (!zero_x_ff && err_le_zero) begin
               err_in   = add_sum;
               hw_in    = hw_ff + 1'b1;
               state_in = ST_GROW_D;
            end else begin
               state_in = ST_ROW_E;
            end
         end

         ST_GROW_D: begin
            dx_in    = add_sum;
            state_in = ST_GROW_E;
         end

         ST_ROW_E: begin
            err_in   = add_sum;
            state_in = ST_ROW_D;
         end

         ST_ROW_D: begin
            dy_in    = add_sum;
            state_in = ST_EMIT;
         end

         ST_EMIT: begin
            if (rsp_free) begin
               out_valid_in = 1'b1;
               out_left_in  = left_sum[CW-1:0];
               out_right_in = right_sum[CW-1:0];
               out_upper_in = org_y_ff + row_ff;
               out_lower_in = org_y_ff - row_ff;
               out_color_in = color_ff;
               out_op_in    = rop_ff;
               out_last_in  = (row_ff == '0);
               out_mis_in   = 1'b0;
               if (row_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  row_in   = row_ff - 1'b1;
                  state_in = ST_WAIT;
               end
            end
         end

         ST_EMIT_ERR: begin
            if (rsp_free) begin
               out_valid_in = 1'b1;
               out_left_in  = '0;
               out_right_in = '0;
               out_upper_in = '0;
               out_lower_in = '0;
               out_color_in = '0;
               out_op_in    = '0;
               out_last_in  = 1'b1;
               out_mis_in   = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         color_ff     <= '0;
         rop_ff       <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         color_ff     <= color_in;
         rop_ff       <= rop_in;
      end
   end

   // datapath and output payload registers
   always_ff @(posedge clock) begin
      org_x_ff     <= org_x_in;
      org_y_ff     <= org_y_in;
      row_ff       <= row_in;
      hw_ff        <= hw_in;
      rx_ff        <= rx_in;
      zero_x_ff    <= zero_x_in;
      xsq_ff       <= xsq_in;
      ysq_ff       <= ysq_in;
      err_ff       <= err_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      acc_ff       <= acc_in;
      mcand_ff     <= mcand_in;
      mplier_ff    <= mplier_in;
      cnt_ff       <= cnt_in;
      out_left_ff  <= out_left_in;
      out_right_ff <= out_right_in;
      out_upper_ff <= out_upper_in;
      out_lower_ff <= out_lower_in;
      out_color_ff <= out_color_in;
      out_op_ff    <= out_op_in;
      out_last_ff  <= out_last_in;
      out_mis_ff   <= out_mis_in;
   end

   // response ports
   assign rsp_valid      = out_valid_ff;
   assign rsp_left_x     = out_left_ff;
   assign rsp_right_x    = out_right_ff;
   assign rsp_upper_row  = out_upper_ff;
   assign rsp_lower_row  = out_lower_ff;
   assign rsp_span_color = out_color_ff;
   assign rsp_span_op    = out_op_ff;
   assign rsp_last_row   = out_last_ff;
   assign rsp_misaligned = out_mis_ff;

endmodule

>>> sim/tb_filled_ellipse_span_generator.sv
// tb_filled_ellipse_span_generator: self-checking bench for the ellipse span generator
// depends on fesg_pkg and filled_ellipse_span_generator; spans predicted in-bench
`timescale 1ns / 1ps

module tb_filled_ellipse_span_generator;
   import fesg_pkg::*;

   localparam int COORD_BITS    = 16;
   localparam int CYCLE_LIMIT   = 3_000_000;
   // a start keeps the block busy for three shift-add products plus setup
   localparam int SETTLE_CYCLES = 3 * (COORD_BITS - 1) + 3 + 16;
   localparam int RANDOM_ITEMS  = 1500;
   localparam int RANDOM_PHASES = 6;
   localparam int LONG_HOLD     = 400;

   typedef enum {RSP_ALWAYS, RSP_RANDOM, RSP_PATTERN} rsp_style_type;

   typedef struct packed {
      logic        mode;
      logic [15:0] center_x;
      logic [15:0] center_y;
      logic [15:0] major_end_x;
      logic [15:0] major_end_y;
      logic [15:0] minor_end_x;
      logic [15:0] minor_end_y;
   } ellipse_req_type;

   typedef struct packed {
      logic [15:0] left_x;
      logic [15:0] right_x;
      logic [15:0] upper_row;
      logic [15:0] lower_row;
      logic [15:0] color;
      logic [15:0] op;
      logic        last_row;
      logic        misaligned;
   } span_type;

   logic clock;
   logic reset;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_data;
   logic req_valid;
   logic req_ready;
   logic req_mode;
   logic signed [COORD_BITS-1:0] req_center_x;
   logic signed [COORD_BITS-1:0] req_center_y;
   logic signed [COORD_BITS-1:0] req_major_end_x;
   logic signed [COORD_BITS-1:0] req_major_end_y;
   logic signed [COORD_BITS-1:0] req_minor_end_x;
   logic signed [COORD_BITS-1:0] req_minor_end_y;
   logic rsp_valid;
   logic rsp_ready;
   logic signed [COORD_BITS-1:0] rsp_left_x;
   logic signed [COORD_BITS-1:0] rsp_right_x;
   logic signed [COORD_BITS-1:0] rsp_upper_row;
   logic signed [COORD_BITS-1:0] rsp_lower_row;
   logic [CSR_DATA_BITS-1:0] rsp_span_color;
   logic [CSR_DATA_BITS-1:0] rsp_span_op;
   logic rsp_last_row;
   logic rsp_misaligned;

   filled_ellipse_span_generator #(
      .COORD_BITS(COORD_BITS)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_center_x    (req_center_x),
      .req_center_y    (req_center_y),
      .req_major_end_x (req_major_end_x),
      .req_major_end_y (req_major_end_y),
      .req_minor_end_x (req_minor_end_x),
      .req_minor_end_y (req_minor_end_y),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_left_x      (rsp_left_x),
      .rsp_right_x     (rsp_right_x),
      .rsp_upper_row   (rsp_upper_row),
      .rsp_lower_row   (rsp_lower_row),
      .rsp_span_color  (rsp_span_color),
      .rsp_span_op     (rsp_span_op),
      .rsp_last_row    (rsp_last_row),
      .rsp_misaligned  (rsp_misaligned)
   );

   // clock
   always #1 clock = ~clock;

   // predicted ellipse state and configuration
   logic               ell_active;
   logic [15:0]        ell_org_x;
   logic [15:0]        ell_org_y;
   logic [15:0]        ell_row;
   logic [31:0]        ell_hw;
   logic signed [63:0] ell_err;
   logic signed [63:0] ell_rx2;
   logic signed [63:0] ell_ry2;
   logic               ell_zero_rx;
   logic [15:0]        cfg_color;
   logic [15:0]        cfg_op;

   span_type span_queue[$];
   int    errors;
   int    useful_items;
   int    cycle_count;

   // sender pacing
   bit gap_enable;
   int burst_left;

   // receiver stall control
   rsp_style_type rsp_style;
   logic [15:0]   rsp_mask;
   int            rsp_mask_pos;
   bit            long_hold_req;
   int            hold_cnt;

   // radius of one endpoint component: wrapped difference magnitude, saturated
   function automatic int unsigned radius_of(logic [15:0] end_v, logic [15:0] ctr);
      logic [15:0] d;
      int unsigned m;
      d = end_v - ctr;
      if (d[15]) begin
         m = 32'd65536 - d;
         if (m > 32767)
            m = 32767;
      end else begin
         m = d;
      end
      return m;
   endfunction

   function automatic logic [15:0] signed_offset(int unsigned mag);
      if ($urandom_range(0, 1))
         return 16'(-int'(mag));
      return 16'(mag);
   endfunction

   function automatic ellipse_req_type random_fields(logic mode);
      ellipse_req_type r;
      r.mode        = mode;
      r.center_x    = 16'($urandom);
      r.center_y    = 16'($urandom);
      r.major_end_x = 16'($urandom);
      r.major_end_y = 16'($urandom);
      r.minor_end_x = 16'($urandom);
      r.minor_end_y = 16'($urandom);
      return r;
   endfunction

   // span prediction for one accepted request
   task automatic predict_item(input ellipse_req_type r);
      logic [15:0] dx1;
      logic [15:0] dx2;
      int unsigned rx;
      int unsigned ry;
      span_type s;
      s = '0;
      if (r.mode == MODE_START) begin
         useful_items++;
         dx1 = r.major_end_x - r.center_x;
         dx2 = r.minor_end_x - r.center_x;
         if (dx1 != 0 && dx2 != 0) begin
            // both axes off the vertical: single error result
            ell_active   = 1'b0;
            s.last_row   = 1'b1;
            s.misaligned = 1'b1;
            span_queue.push_back(s);
         end else begin
            rx = (dx1 == 0) ? radius_of(r.major_end_y, r.center_y)
                            : radius_of(r.major_end_x, r.center_x);
            ry = (dx2 == 0) ? radius_of(r.minor_end_y, r.center_y)
                            : radius_of(r.minor_end_x, r.center_x);
            ell_org_x   = r.center_x;
            ell_org_y   = r.center_y;
            ell_row     = 16'(ry);
            ell_rx2     = 64'(rx) * 64'(rx);
            ell_ry2     = 64'(ry) * 64'(ry);
            ell_zero_rx = (rx == 0);
            if (rx == 0) begin
               ell_hw  = 1;
               ell_err = 0;
            end else if (ry == 0) begin
               // flat ellipse: one row at full width
               ell_hw  = rx;
               ell_err = 1;
            end else begin
               ell_hw  = 0;
               ell_err = 64'sd0 - 64'(ry) * ell_rx2;
            end
            ell_active = 1'b1;
         end
      end else if (ell_active) begin
         useful_items++;
         // widen while the scaled midpoint error is non-positive
         if (!ell_zero_rx) begin
            while (ell_err <= 0) begin
               ell_err = ell_err + ell_ry2 * (64'(ell_hw) * 2 + 1);
               ell_hw  = ell_hw + 1;
            end
         end
         if (ell_row != 0)
            ell_err = ell_err - ell_rx2 * (64'(ell_row) * 2 - 1);
         else
            ell_err = ell_err + ell_rx2;
         s.left_x    = ell_org_x - ell_hw[15:0];
         s.right_x   = ell_org_x + ell_hw[15:0];
         s.upper_row = ell_org_y + ell_row;
         s.lower_row = ell_org_y - ell_row;
         s.color     = cfg_color;
         s.op        = cfg_op;
         s.last_row  = (ell_row == 0);
         span_queue.push_back(s);
         if (ell_row == 0)
            ell_active = 1'b0;
         else
            ell_row = ell_row - 1;
      end
   endtask

   // one request transfer, with burst/gap pacing
   task automatic send_item(input ellipse_req_type r);
      int gap;
      @(negedge clock);
      if (gap_enable && burst_left <= 0) begin
         req_valid = 1'b0;
         gap = $urandom_range(1, 12);
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_mode        = r.mode;
      req_center_x    = r.center_x;
      req_center_y    = r.center_y;
      req_major_end_x = r.major_end_x;
      req_major_end_y = r.major_end_y;
      req_minor_end_x = r.minor_end_x;
      req_minor_end_y = r.minor_end_y;
      req_valid       = 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_item(r);
   endtask

   task automatic send_start(input logic [15:0] cx, input logic [15:0] cy,
                             input logic [15:0] mjx, input logic [15:0] mjy,
                             input logic [15:0] mnx, input logic [15:0] mny);
      ellipse_req_type r;
      r = '{MODE_START, cx, cy, mjx, mjy, mnx, mny};
      send_item(r);
   endtask

   task automatic send_steps(input int n);
      repeat (n) send_item(random_fields(MODE_STEP));
   endtask

   // sender stops until every predicted span is back, then lets the block settle
   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (span_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] val);
      @(negedge clock);
      csr_index = idx;
      csr_data  = val;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_FILL_COLOR)
         cfg_color = val;
      else if (idx == CSR_RASTER_OP)
         cfg_op = val;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic apply_config(input logic [15:0] color, input logic [15:0] op);
      wait_drained();
      write_csr(CSR_FILL_COLOR, color);
      write_csr(CSR_RASTER_OP, op);
   endtask

   // steps before any ellipse, then a small ellipse with the reset configuration
   task automatic test_reset_config();
      send_steps(2);
      send_start(16'd100, -16'sd50, 16'd103, 16'd7, 16'd100, -16'sd48);
      send_steps(4);
   endtask

   // misaligned axes, including while an ellipse is in progress
   task automatic test_misaligned();
      send_start(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8001, 16'h0000);
      send_start(16'd10, 16'd10, 16'd10, 16'd15, 16'd10, 16'd14);
      send_steps(1);
      send_start(16'd0, 16'd0, 16'd5, 16'd0, -16'sd3, 16'd9);
      send_steps(1);
   endtask

   // zero x radius, single point, flat ellipse
   task automatic test_degenerate();
      send_start(-16'sd7, 16'd300, -16'sd7, 16'd300, -16'sd7, 16'd302);
      send_steps(3);
      send_start(16'd5, 16'd5, 16'd5, 16'd5, 16'd5, 16'd5);
      send_steps(1);
      send_start(16'd0, 16'd0, 16'd5, 16'd0, 16'd0, 16'd0);
      send_steps(1);
   endtask

   // saturated radius with coordinate wrap, and both radii at full size
   task automatic test_extremes();
      send_start(16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000, 16'h8000, 16'd12345);
      send_steps(2);
      send_start(16'h8000, 16'h7FFF, 16'hFFFF, 16'h8000, 16'h8000, 16'h0000);
      send_steps(2);
   endtask

   // long receiver hold while steps keep coming, then a full drain
   task automatic test_backpressure();
      wait_drained();
      gap_enable    = 1'b0;
      long_hold_req = 1'b1;
      send_start(16'd1000, -16'sd1000, 16'd1020, 16'd0, 16'd1000, -16'sd940);
      send_steps(61);
      wait_drained();
   endtask

   // one random sequence: mostly well-formed ellipses, some noise
   task automatic random_item();
      int unsigned kind;
      int unsigned rx;
      int unsigned ry;
      int unsigned sz;
      int unsigned orient;
      int unsigned pick;
      int nsteps;
      ellipse_req_type r;
      kind = $urandom_range(0, 99);
      r    = random_fields(MODE_START);
      if (kind < 6) begin
         send_item(r);
      end else if (kind < 10) begin
         send_steps($urandom_range(1, 3));
      end else if (kind < 16) begin
         r.major_end_x = r.center_x + 16'($urandom_range(1, 65535));
         r.minor_end_x = r.center_x + 16'($urandom_range(1, 65535));
         send_item(r);
      end else begin
         // radii: mostly small, now and then up to full size
         sz = $urandom_range(0, 99);
         rx = (sz < 85) ? $urandom_range(0, 12) : (sz < 97) ? $urandom_range(0, 200) :
              (sz < 99) ? $urandom_range(0, 4000) : $urandom_range(0, 32768);
         sz = $urandom_range(0, 99);
         ry = (sz < 85) ? $urandom_range(0, 12) : (sz < 98) ? $urandom_range(0, 100) :
              $urandom_range(0, 32768);
         orient = $urandom_range(0, 2);
         if (orient == 0) begin
            r.major_end_x = r.center_x + signed_offset(rx);
            if (rx == 0)
               r.major_end_y = r.center_y;
            r.minor_end_x = r.center_x;
            r.minor_end_y = r.center_y + signed_offset(ry);
         end else begin
            r.major_end_x = r.center_x;
            r.major_end_y = r.center_y + signed_offset(rx);
            if (orient == 1) begin
               r.minor_end_x = r.center_x + signed_offset(ry);
               if (ry == 0)
                  r.minor_end_y = r.center_y;
            end else begin
               r.minor_end_x = r.center_x;
               r.minor_end_y = r.center_y + signed_offset(ry);
            end
         end
         send_item(r);
         if (ry > 32767)
            ry = 32767;
         pick = $urandom_range(0, 9);
         if (ry > 400)
            nsteps = $urandom_range(1, 20);
         else if (pick < 7)
            nsteps = ry + 1;
         else if (pick < 9)
            nsteps = $urandom_range(0, ry);
         else
            nsteps = ry + 1 + $urandom_range(1, 3);
         send_steps(nsteps);
      end
   endtask

   // random phases, each under its own configuration and receiver behavior
   task automatic test_random();
      int phase_end;
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0:       apply_config(16'hFFFF, 16'hFFFF);
            1:       apply_config(16'h0000, 16'h0000);
            default: apply_config(16'($urandom), 16'($urandom));
         endcase
         rsp_style  = rsp_style_type'(ph % 3);
         rsp_mask   = 16'($urandom) | 16'h0001;
         gap_enable = (ph != 2);
         phase_end  = useful_items + RANDOM_ITEMS / RANDOM_PHASES;
         while (useful_items < phase_end)
            random_item();
      end
   endtask

   // receiver ready: long hold on request, otherwise the current style
   always @(negedge clock) begin
      if (long_hold_req) begin
         hold_cnt      = LONG_HOLD;
         long_hold_req = 1'b0;
      end
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_ready = 1'b0;
      end else begin
         case (rsp_style)
            RSP_ALWAYS: rsp_ready = 1'b1;
            RSP_RANDOM: rsp_ready = ($urandom_range(0, 3) != 0);
            default: begin
               rsp_ready    = rsp_mask[rsp_mask_pos];
               rsp_mask_pos = (rsp_mask_pos + 1) % 16;
            end
         endcase
      end
   end

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got_v);
      if (want !== got_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got_v);
      end
   endtask

   // compare each result transfer against the oldest prediction
   always @(posedge clock) begin : check_spans
      span_type got;
      span_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_left_x, rsp_right_x, rsp_upper_row, rsp_lower_row,
                 rsp_span_color, rsp_span_op, rsp_last_row, rsp_misaligned};
         if (span_queue.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual %p", $time, got);
         end else begin
            want = span_queue.pop_front();
            check_field("left_x", want.left_x, got.left_x);
            check_field("right_x", want.right_x, got.right_x);
            check_field("upper_row", want.upper_row, got.upper_row);
            check_field("lower_row", want.lower_row, got.lower_row);
            check_field("span_color", want.color, got.color);
            check_field("span_op", want.op, got.op);
            check_field("last_row", 16'(want.last_row), 16'(got.last_row));
            check_field("misaligned", 16'(want.misaligned), 16'(got.misaligned));
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run limit reached, %0d results outstanding", $time,
                  span_queue.size());
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      clock           = 1'b0;
      reset           = 1'b1;
      csr_valid       = 1'b0;
      csr_index       = CSR_FILL_COLOR;
      csr_data        = '0;
      req_valid       = 1'b0;
      req_mode        = MODE_START;
      req_center_x    = '0;
      req_center_y    = '0;
      req_major_end_x = '0;
      req_major_end_y = '0;
      req_minor_end_x = '0;
      req_minor_end_y = '0;
      rsp_ready       = 1'b0;
      ell_active      = 1'b0;
      ell_org_x       = '0;
      ell_org_y       = '0;
      ell_row         = '0;
      ell_hw          = '0;
      ell_err         = '0;
      ell_rx2         = '0;
      ell_ry2         = '0;
      ell_zero_rx     = 1'b0;
      cfg_color       = '0;
      cfg_op          = '0;
      errors          = 0;
      useful_items    = 0;
      cycle_count     = 0;
      gap_enable      = 1'b1;
      burst_left      = 0;
      rsp_style       = RSP_RANDOM;
      rsp_mask        = 16'hB5A7;
      rsp_mask_pos    = 0;
      long_hold_req   = 1'b0;
      hold_cnt        = 0;

      // reset
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_config();
      apply_config(16'hFFFF, 16'h0000);
      test_misaligned();
      test_degenerate();
      apply_config(16'h0000, 16'hFFFF);
      test_extremes();
      test_backpressure();
      test_random();

      wait_drained();
      if (span_queue.size() != 0) begin
         errors++;
         $display("%0t: %0d expected results never arrived", $time, span_queue.size());
      end
      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

>>> filled_ellipse_span_generator.f
rtl/core/fesg_pkg.sv
rtl/core/filled_ellipse_span_generator.sv
sim/tb_filled_ellipse_span_generator.sv
